// ===== rtl/camera_ray_direction_generator_defines.svh =====
// assertion macros for the ray direction pipeline
`ifndef CAMERA_RAY_DIRECTION_GENERATOR_DEFINES_SVH
`define CAMERA_RAY_DIRECTION_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define CRDG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CRDG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRDG_ASSERT_SAME(label, ante, cons, msg)
`define CRDG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/crdg_pkg.sv =====
`default_nettype none

package crdg_pkg;

  localparam int unsigned COMPONENT_WIDTH = 16;
  localparam int unsigned COORD_W         = 17;
  localparam int unsigned REG_W           = 48;
  localparam int unsigned REG_IDX_W       = 2;
  localparam int unsigned DIR_W           = 16;
  localparam int unsigned CORNER_SHIFT    = 16;

  localparam int unsigned REG_EXT_W = (3 * COMPONENT_WIDTH > REG_W) ? 3 * COMPONENT_WIDTH : REG_W;
  localparam int unsigned PROD_W    = COMPONENT_WIDTH + COORD_W + 1;
  localparam int unsigned SUM_W     = COMPONENT_WIDTH + 19;
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned POS_W     = $clog2(MAG_W);
  localparam int unsigned CHUNK     = 8;
  localparam int unsigned NCHUNK    = (MAG_W + CHUNK - 1) / CHUNK;
  localparam int unsigned CHUNK_W   = $clog2(CHUNK);

  localparam int unsigned NRM_W      = 24;
  localparam int unsigned NRM_TOP    = NRM_W - 1;
  localparam int unsigned LEN_W      = 2 * NRM_W + 2;
  localparam int unsigned ROOT_W     = LEN_W / 2;
  localparam int unsigned SQ_REM_W   = ROOT_W + 3;
  localparam int unsigned UNIT_SHIFT = 14;
  localparam int unsigned UNIT_ONE   = 1 << UNIT_SHIFT;
  localparam int unsigned Q_W        = UNIT_SHIFT + 1;
  localparam int unsigned NUM_W      = NRM_W + UNIT_SHIFT + 1;
  localparam int unsigned DIV_REM_W  = ROOT_W + 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CORNER = 2'd0,
    REG_HSPAN  = 2'd1,
    REG_VSPAN  = 2'd2
  } reg_idx_e;

  // packed component idx of a basis register, bits above the register read as zero
  function automatic logic signed [COMPONENT_WIDTH-1:0] get_comp(
    input logic [REG_W-1:0] r,
    input int unsigned      idx
  );
    logic [REG_EXT_W-1:0] ext;
    ext = REG_EXT_W'(r);
    return $signed(ext[idx*COMPONENT_WIDTH +: COMPONENT_WIDTH]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/camera_ray_direction_generator.sv =====
// channel   ports                                          transfer when
// command   start, busy, coord_u_i, coord_v_i              start high and busy low
// result    done_o, dir_x_o, dir_y_o, dir_z_o, degenerate_o done_o high, one cycle
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i               cfg_we_i high
//
// one item per clock, busy stays low
// a result shows on done_o after eight setup stages, a 25-step square root
// pipeline and a 15-step divider pipeline, each behind its own input register,
// and the output register; reset clears the valid bits and the basis registers
// the result side cannot stall, so the pipeline always advances
`default_nettype none

`include "camera_ray_direction_generator_defines.svh"

module camera_ray_direction_generator import crdg_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [COORD_W-1:0]          coord_u_i,
  input  wire logic [COORD_W-1:0]          coord_v_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [REG_W-1:0]            cfg_wdata_i,
  output logic                             done_o,
  output logic signed [DIR_W-1:0]          dir_x_o,
  output logic signed [DIR_W-1:0]          dir_y_o,
  output logic signed [DIR_W-1:0]          dir_z_o,
  output logic                             degenerate_o
);

  logic [REG_W-1:0] corner_q, hspan_q, vspan_q;

  logic                                 s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic                                 s5_vld_q, s6_vld_q, s7_vld_q, s8_vld_q;
  logic [2:0][COMPONENT_WIDTH-1:0]      s1_c_q;
  logic [2:0][PROD_W-1:0]               s1_hu_q, s1_sv_q;
  logic [2:0][PROD_W-1:0]               hu_d, sv_d;
  logic [2:0][SUM_W-1:0]                s2_d_q, sum_d;
  logic [2:0][MAG_W-1:0]                s3_mag_q, mag_d;
  logic [2:0]                           s3_neg_q;
  logic [2:0][MAG_W-1:0]                s4_mag_q;
  logic [MAG_W-1:0]                     s4_max_q, max_d;
  logic [2:0]                           s4_neg_q;
  logic [2:0][MAG_W-1:0]                s5_mag_q;
  logic [2:0]                           s5_neg_q;
  logic                                 s5_deg_q;
  logic [NCHUNK-1:0]                    s5_nz_q, nz_d;
  logic [NCHUNK-1:0][CHUNK_W-1:0]       s5_lpos_q, lpos_d;
  logic [2:0][MAG_W-1:0]                s6_mag_q;
  logic [2:0]                           s6_neg_q;
  logic                                 s6_deg_q, s6_right_q;
  logic [POS_W-1:0]                     s6_amt_q;
  logic [POS_W-1:0]                     pos_d;
  logic [2:0][NRM_W-1:0]                s7_nrm_q, nrm_d;
  logic [2:0]                           s7_neg_q;
  logic                                 s7_deg_q;
  logic [2:0][NRM_W-1:0]                s8_nrm_q;
  logic [2:0][2*NRM_W-1:0]              s8_sq_q;
  logic [2:0]                           s8_neg_q;
  logic                                 s8_deg_q;

  logic                                 sq_vld_q  [ROOT_W+1];
  logic [LEN_W-1:0]                     sq_rad_q  [ROOT_W+1];
  logic [SQ_REM_W-1:0]                  sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]                    sq_root_q [ROOT_W+1];
  logic [2:0][NRM_W-1:0]                sq_nrm_q  [ROOT_W+1];
  logic [2:0]                           sq_neg_q  [ROOT_W+1];
  logic                                 sq_deg_q  [ROOT_W+1];

  logic                                 dv_vld_q  [Q_W+1];
  logic [2:0][DIV_REM_W-1:0]            dv_rem_q  [Q_W+1];
  logic [2:0][Q_W-1:0]                  dv_low_q  [Q_W+1];
  logic [ROOT_W-1:0]                    dv_root_q [Q_W+1];
  logic [2:0]                           dv_neg_q  [Q_W+1];
  logic                                 dv_deg_q  [Q_W+1];

  logic [2:0][NUM_W-1:0]                num_d;
  logic [2:0][DIR_W-1:0]                dir_d;

  assign busy = 1'b0;

  // basis registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      hspan_q  <= '0;
      vspan_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CORNER: corner_q <= cfg_wdata_i;
        REG_HSPAN:  hspan_q  <= cfg_wdata_i;
        REG_VSPAN:  vspan_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // valid bits of the setup stages, the square root and divider inputs, and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      sq_vld_q[0] <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      done_o <= 1'b0;
    end else begin
      s1_vld_q <= start & ~busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      s8_vld_q <= s7_vld_q;
      sq_vld_q[0] <= s8_vld_q;
      dv_vld_q[0] <= sq_vld_q[ROOT_W];
      done_o <= dv_vld_q[Q_W];
    end
  end

  // edge vector products, direction sum, magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hu_d[i] = $signed(get_comp(hspan_q, i)) * $signed({1'b0, coord_u_i});
      sv_d[i] = $signed(get_comp(vspan_q, i)) * $signed({1'b0, coord_v_i});
      sum_d[i] = (SUM_W'($signed(s1_c_q[i])) <<< CORNER_SHIFT)
               + SUM_W'($signed(s1_hu_q[i])) + SUM_W'($signed(s1_sv_q[i]));
      mag_d[i] = s2_d_q[i][SUM_W-1] ? MAG_W'(SUM_W'(0) - s2_d_q[i]) : MAG_W'(s2_d_q[i]);
    end
  end

  // largest magnitude
  always_comb begin
    logic [MAG_W-1:0] m01;
    m01   = (s3_mag_q[0] > s3_mag_q[1]) ? s3_mag_q[0] : s3_mag_q[1];
    max_d = (m01 > s3_mag_q[2]) ? m01 : s3_mag_q[2];
  end

  // leading one search, first per byte then across bytes
  always_comb begin
    logic [NCHUNK*CHUNK-1:0] padded;
    logic [CHUNK-1:0]        ch;
    padded = (NCHUNK*CHUNK)'(s4_max_q);
    for (int j = 0; j < NCHUNK; j++) begin
      ch        = padded[j*CHUNK +: CHUNK];
      nz_d[j]   = |ch;
      lpos_d[j] = '0;
      for (int b = 0; b < CHUNK; b++) begin
        if (ch[b]) lpos_d[j] = CHUNK_W'(b);
      end
    end
  end

  always_comb begin
    pos_d = '0;
    for (int j = 0; j < NCHUNK; j++) begin
      if (s5_nz_q[j]) pos_d = POS_W'(j * CHUNK) + POS_W'(s5_lpos_q[j]);
    end
  end

  // common scaling so the largest magnitude has its top bit at NRM_TOP
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_d[i] = s6_right_q ? NRM_W'(s6_mag_q[i] >> s6_amt_q)
                            : NRM_W'(s6_mag_q[i] << s6_amt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_c_q[i]  <= get_comp(corner_q, i);
      s1_hu_q[i] <= hu_d[i];
      s1_sv_q[i] <= sv_d[i];
      s2_d_q[i]  <= sum_d[i];
      s3_neg_q[i] <= s2_d_q[i][SUM_W-1];
      s3_mag_q[i] <= mag_d[i];
      s8_sq_q[i] <= s7_nrm_q[i] * s7_nrm_q[i];
    end
    s4_mag_q  <= s3_mag_q;
    s4_neg_q  <= s3_neg_q;
    s4_max_q  <= max_d;
    s5_mag_q  <= s4_mag_q;
    s5_neg_q  <= s4_neg_q;
    s5_deg_q  <= ~|nz_d;
    s5_nz_q   <= nz_d;
    s5_lpos_q <= lpos_d;
    s6_mag_q  <= s5_mag_q;
    s6_neg_q  <= s5_neg_q;
    s6_deg_q  <= s5_deg_q;
    s6_right_q <= (pos_d >= POS_W'(NRM_TOP));
    s6_amt_q  <= (pos_d >= POS_W'(NRM_TOP)) ? pos_d - POS_W'(NRM_TOP)
                                             : POS_W'(NRM_TOP) - pos_d;
    s7_nrm_q  <= nrm_d;
    s7_neg_q  <= s6_neg_q;
    s7_deg_q  <= s6_deg_q;
    s8_nrm_q  <= s7_nrm_q;
    s8_neg_q  <= s7_neg_q;
    s8_deg_q  <= s7_deg_q;
    sq_rad_q[0]  <= LEN_W'(s8_sq_q[0]) + LEN_W'(s8_sq_q[1]) + LEN_W'(s8_sq_q[2]);
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_nrm_q[0]  <= s8_nrm_q;
    sq_neg_q[0]  <= s8_neg_q;
    sq_deg_q[0]  <= s8_deg_q;
  end

  // square root, one root bit per stage
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] t, trial;

    always_comb begin
      t     = {sq_rem_q[k-1][SQ_REM_W-3:0], sq_rad_q[k-1][LEN_W-1 -: 2]};
      trial = SQ_REM_W'({sq_root_q[k-1], 2'b01});
    end

    always_ff @(posedge clk_i) begin
      if (t >= trial) begin
        sq_rem_q[k]  <= t - trial;
        sq_root_q[k] <= {sq_root_q[k-1][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_q[k]  <= t;
        sq_root_q[k] <= {sq_root_q[k-1][ROOT_W-2:0], 1'b0};
      end
      sq_rad_q[k] <= sq_rad_q[k-1] << 2;
      sq_nrm_q[k] <= sq_nrm_q[k-1];
      sq_neg_q[k] <= sq_neg_q[k-1];
      sq_deg_q[k] <= sq_deg_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
    end
  end

  // rounded dividend a * one + r / 2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = NUM_W'({sq_nrm_q[ROOT_W][i], {UNIT_SHIFT{1'b0}}})
               + NUM_W'(sq_root_q[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] <= DIV_REM_W'(num_d[i][NUM_W-1:Q_W]);
      dv_low_q[0][i] <= num_d[i][Q_W-1:0];
    end
    dv_root_q[0] <= sq_root_q[ROOT_W];
    dv_neg_q[0]  <= sq_neg_q[ROOT_W];
    dv_deg_q[0]  <= sq_deg_q[ROOT_W];
  end

  // restoring divide by the root, one quotient bit per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    logic [2:0][DIV_REM_W-1:0] t;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {dv_rem_q[k-1][i][DIV_REM_W-2:0], dv_low_q[k-1][i][Q_W-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (t[i] >= DIV_REM_W'(dv_root_q[k-1])) begin
          dv_rem_q[k][i] <= t[i] - DIV_REM_W'(dv_root_q[k-1]);
          dv_low_q[k][i] <= {dv_low_q[k-1][i][Q_W-2:0], 1'b1};
        end else begin
          dv_rem_q[k][i] <= t[i];
          dv_low_q[k][i] <= {dv_low_q[k-1][i][Q_W-2:0], 1'b0};
        end
      end
      dv_root_q[k] <= dv_root_q[k-1];
      dv_neg_q[k]  <= dv_neg_q[k-1];
      dv_deg_q[k]  <= dv_deg_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end
  end

  // clamp, sign, zero direction
  always_comb begin
    logic [Q_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = dv_low_q[Q_W][i];
      if (q > Q_W'(UNIT_ONE)) q = Q_W'(UNIT_ONE);
      if (dv_deg_q[Q_W]) begin
        dir_d[i] = '0;
      end else if (dv_neg_q[Q_W][i]) begin
        dir_d[i] = DIR_W'(0) - DIR_W'(q);
      end else begin
        dir_d[i] = DIR_W'(q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dir_x_o      <= dir_d[0];
    dir_y_o      <= dir_d[1];
    dir_z_o      <= dir_d[2];
    degenerate_o <= dv_deg_q[Q_W];
  end

  `CRDG_ASSERT_NEXT(a_scale_top_bit, s6_vld_q && !s6_deg_q,
    (s7_nrm_q[0][NRM_TOP] | s7_nrm_q[1][NRM_TOP] | s7_nrm_q[2][NRM_TOP]),
    "scaled largest magnitude lost its top bit")
  `CRDG_ASSERT_SAME(a_root_range, dv_vld_q[0] && !dv_deg_q[0],
    dv_root_q[0][ROOT_W-1 -: 2] != 2'b00, "vector length below scaled range")
  `CRDG_ASSERT_SAME(a_dir_range, done_o && !degenerate_o,
    dir_x_o <= 16'sd16384 && dir_x_o >= -16'sd16384 &&
    dir_y_o <= 16'sd16384 && dir_y_o >= -16'sd16384 &&
    dir_z_o <= 16'sd16384 && dir_z_o >= -16'sd16384, "direction out of unit range")
  `CRDG_ASSERT_SAME(a_dir_nonzero, done_o && !degenerate_o,
    dir_x_o != 16'sd0 || dir_y_o != 16'sd0 || dir_z_o != 16'sd0,
    "zero direction without degenerate flag")

endmodule

`default_nettype wire

// ===== tb/tb_camera_ray_direction_generator.sv =====
`timescale 1ns / 100ps

module tb_camera_ray_direction_generator;
  import crdg_pkg::*;

  localparam int unsigned LATENCY     = 50;
  localparam int unsigned SETTLE      = LATENCY + 14;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_RAYS  = 200;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned FRAC_SCALE  = 1 << CORNER_SHIFT;
  localparam longint unsigned NORM_LO = 64'd1 << (NRM_W - 1);
  localparam longint unsigned NORM_HI = 64'd1 << NRM_W;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(FRAC_SCALE);
  localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef enum logic [1:0] {
    ITEM_RAY,
    CFG_WRITE,
    HOLD_DRAIN
  } op_kind_e;

  typedef struct {
    op_kind_e               kind;
    logic [COORD_W-1:0]     u;
    logic [COORD_W-1:0]     v;
    logic [REG_IDX_W-1:0]   idx;
    logic [REG_W-1:0]       data;
    int unsigned            gap_pct;
  } pending_t;

  typedef struct packed {
    logic [COORD_W-1:0]       u;
    logic [COORD_W-1:0]       v;
    logic signed [DIR_W-1:0]  x;
    logic signed [DIR_W-1:0]  y;
    logic signed [DIR_W-1:0]  z;
    logic                     degen;
  } ray_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        start       = 1'b0;
  logic                        busy;
  logic [COORD_W-1:0]          coord_u     = '0;
  logic [COORD_W-1:0]          coord_v     = '0;
  logic                        cfg_we      = 1'b0;
  logic [REG_IDX_W-1:0]        cfg_idx     = REG_CORNER;
  logic [REG_W-1:0]            cfg_wdata   = '0;
  logic                        done_o;
  logic signed [DIR_W-1:0]     dir_x_o;
  logic signed [DIR_W-1:0]     dir_y_o;
  logic signed [DIR_W-1:0]     dir_z_o;
  logic                        degenerate_o;

  pending_t          pend_q[$];
  ray_t              ray_exp_q[$];
  logic [REG_W-1:0]  corner_q = '0;
  logic [REG_W-1:0]  hspan_q  = '0;
  logic [REG_W-1:0]  vspan_q  = '0;
  int unsigned       acc_cnt  = 0;
  int unsigned       chk_cnt  = 0;
  int unsigned       mism_cnt = 0;
  int unsigned       degen_cnt = 0;
  int unsigned       basis_cnt = 0;
  int unsigned       cycle_cnt = 0;

  camera_ray_direction_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .coord_u_i    (coord_u),
    .coord_v_i    (coord_v),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .done_o       (done_o),
    .dir_x_o      (dir_x_o),
    .dir_y_o      (dir_y_o),
    .dir_z_o      (dir_z_o),
    .degenerate_o (degenerate_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // unit direction of corner + hspan*u + vspan*v under the current basis
  function automatic ray_t predict_ray(input logic [COORD_W-1:0] u,
                                       input logic [COORD_W-1:0] v);
    longint            cu, cv, sum;
    longint unsigned   mag [3];
    logic              neg [3];
    longint unsigned   peak, len2, root, trial, quo;
    logic [DIR_W-1:0]  unit [3];
    int unsigned       rsh, lsh;
    ray_t              r;
    cu   = longint'(u);
    cv   = longint'(v);
    peak = 0;
    rsh  = 0;
    lsh  = 0;
    for (int k = 0; k < 3; k++) begin
      sum = longint'($signed(corner_q[k*COMPONENT_WIDTH +: COMPONENT_WIDTH])) * FRAC_SCALE
          + longint'($signed(hspan_q[k*COMPONENT_WIDTH +: COMPONENT_WIDTH])) * cu
          + longint'($signed(vspan_q[k*COMPONENT_WIDTH +: COMPONENT_WIDTH])) * cv;
      neg[k] = sum < 0;
      mag[k] = neg[k] ? longint'(-sum) : longint'(sum);
      if (mag[k] > peak) peak = mag[k];
    end
    r.u = u;
    r.v = v;
    if (peak == 0) begin
      r.x = '0;
      r.y = '0;
      r.z = '0;
      r.degen = 1'b1;
      return r;
    end
    while (peak >= NORM_HI) begin
      peak >>= 1;
      rsh++;
    end
    while (peak < NORM_LO) begin
      peak <<= 1;
      lsh++;
    end
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (mag[k] >> rsh) << lsh;
      len2 += mag[k] * mag[k];
    end
    root = 0;
    for (int b = NRM_W + 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= len2) root = trial;
    end
    for (int k = 0; k < 3; k++) begin
      quo = (mag[k] * UNIT_ONE + (root >> 1)) / root;
      if (quo > UNIT_ONE) quo = UNIT_ONE;
      unit[k] = neg[k] ? -quo[DIR_W-1:0] : quo[DIR_W-1:0];
    end
    r.x = unit[0];
    r.y = unit[1];
    r.z = unit[2];
    r.degen = 1'b0;
    return r;
  endfunction

  // driver: one transfer per accepted start, register writes only when drained
  always @(posedge clk_i or negedge rst_ni) begin
    pending_t              nxt;
    logic                  took;
    logic                  drained;
    logic                  drv_start;
    logic                  drv_we;
    logic [REG_IDX_W-1:0]  drv_idx;
    logic [REG_W-1:0]      drv_data;
    logic [COORD_W-1:0]    drv_u;
    logic [COORD_W-1:0]    drv_v;
    if (!rst_ni) begin
      start     <= 1'b0;
      coord_u   <= '0;
      coord_v   <= '0;
      cfg_we    <= 1'b0;
      cfg_idx   <= REG_CORNER;
      cfg_wdata <= '0;
      acc_cnt   <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        ray_exp_q.push_back(predict_ray(coord_u, coord_v));
        acc_cnt <= acc_cnt + 1;
      end
      drained   = !took && (acc_cnt == chk_cnt);
      drv_start = start;
      drv_we    = 1'b0;
      drv_idx   = cfg_idx;
      drv_data  = cfg_wdata;
      drv_u     = coord_u;
      drv_v     = coord_v;
      if (took || !start) begin
        drv_start = 1'b0;
        if (pend_q.size() != 0) begin
          nxt = pend_q[0];
          case (nxt.kind)
            ITEM_RAY: begin
              if ($urandom_range(99) >= nxt.gap_pct) begin
                drv_start = 1'b1;
                drv_u     = nxt.u;
                drv_v     = nxt.v;
                void'(pend_q.pop_front());
              end
            end
            CFG_WRITE: begin
              if (drained) begin
                drv_we   = 1'b1;
                drv_idx  = nxt.idx;
                drv_data = nxt.data;
                case (nxt.idx)
                  REG_CORNER: corner_q = nxt.data;
                  REG_HSPAN:  hspan_q  = nxt.data;
                  REG_VSPAN:  vspan_q  = nxt.data;
                  default: ;
                endcase
                void'(pend_q.pop_front());
              end
            end
            default: begin
              if (drained) void'(pend_q.pop_front());
            end
          endcase
        end
      end
      start     <= drv_start;
      coord_u   <= drv_u;
      coord_v   <= drv_v;
      cfg_we    <= drv_we;
      cfg_idx   <= drv_idx;
      cfg_wdata <= drv_data;
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    ray_t want;
    if (rst_ni && done_o) begin
      if (ray_exp_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS)
          $display("unexpected result: dir=(%0d,%0d,%0d) degenerate=%0b",
                   dir_x_o, dir_y_o, dir_z_o, degenerate_o);
      end else begin
        want = ray_exp_q.pop_front();
        chk_cnt <= chk_cnt + 1;
        if (want.degen) degen_cnt++;
        if (dir_x_o !== want.x || dir_y_o !== want.y || dir_z_o !== want.z ||
            degenerate_o !== want.degen) begin
          mism_cnt++;
          if (mism_cnt <= MAX_REPORTS)
            $display("mismatch u=%0d v=%0d: expected (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                     want.u, want.v, want.x, want.y, want.z, want.degen,
                     dir_x_o, dir_y_o, dir_z_o, degenerate_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [REG_W-1:0] pack_vec(input int x, input int y, input int z);
    logic [COMPONENT_WIDTH-1:0] cx, cy, cz;
    cx = COMPONENT_WIDTH'(x);
    cy = COMPONENT_WIDTH'(y);
    cz = COMPONENT_WIDTH'(z);
    return REG_W'({cz, cy, cx});
  endfunction

  function automatic int pick_comp(input int unsigned style);
    int tbl [4];
    tbl = '{-32768, 32767, 0, -1};
    case (style)
      0: return $urandom_range(24576) - 12288;
      1: return int'($signed(COMPONENT_WIDTH'($urandom)));
      2: return tbl[2'($urandom_range(3))];
      default: return $urandom_range(16) - 8;
    endcase
  endfunction

  task automatic add_ray(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                         input int unsigned gap);
    pend_q.push_back('{ITEM_RAY, u, v, REG_CORNER, '0, gap});
  endtask

  task automatic add_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    pend_q.push_back('{CFG_WRITE, '0, '0, idx, data, 0});
  endtask

  task automatic add_basis(input logic [REG_W-1:0] c, input logic [REG_W-1:0] h,
                           input logic [REG_W-1:0] s);
    add_write(REG_CORNER, c);
    add_write(REG_HSPAN, h);
    add_write(REG_VSPAN, s);
    basis_cnt++;
  endtask

  task automatic add_drain();
    pend_q.push_back('{HOLD_DRAIN, '0, '0, REG_CORNER, '0, 0});
  endtask

  initial begin
    int unsigned gaps [4];
    int unsigned gap, style, pick;
    logic [COORD_W-1:0] u, v;
    gaps = '{0, 77, 0, 24};

    // registers still at reset: zero direction
    add_ray(0, 0, 0);
    add_ray(COORD_MAX, COORD_MAX, 0);

    // ordinary viewport, corner (-2,-1,-1), spans (4,0,0) and (0,2,0)
    add_basis(pack_vec(-8192, -4096, -4096), pack_vec(16384, 0, 0), pack_vec(0, 8192, 0));
    add_ray(0, 0, 0);
    add_ray(COORD_ONE, 0, 0);
    add_ray(0, COORD_ONE, 0);
    add_ray(COORD_ONE, COORD_ONE, 0);
    add_ray(COORD_ONE >> 1, COORD_ONE >> 1, 0);
    add_ray(COORD_MAX, 0, 0);
    add_ray(0, COORD_MAX, 0);
    add_ray(1, 1, 0);
    add_ray(17'h15555, 17'h0aaaa, 0);
    add_ray(17'h0aaaa, 17'h15555, 0);

    // extreme components
    add_basis(pack_vec(-32768, 32767, -32768), pack_vec(32767, -32768, 32767),
              pack_vec(-32768, -32768, 32767));
    add_ray(0, 0, 0);
    add_ray(COORD_MAX, COORD_MAX, 0);
    add_ray(COORD_ONE, 1, 0);

    // corner cancelled by the horizontal span at u = 1.0
    add_basis(pack_vec(-4096, 4096, 0), pack_vec(4096, -4096, 0), '0);
    add_ray(COORD_ONE, 0, 0);
    add_ray(COORD_ONE, COORD_MAX, 0);
    add_ray(COORD_ONE - COORD_W'(1), 7, 0);

    // write to an unused index leaves the basis alone
    add_write(REG_NONE, REG_W'({$urandom, $urandom}));
    add_ray(12345, 54321, 0);

    // tiny direction, large left shift
    add_basis(pack_vec(1, 0, 0), '0, '0);
    add_ray(0, 0, 0);
    add_basis(pack_vec(0, 0, -1), '0, '0);
    add_ray(0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      gap   = gaps[2'(p % 4)];
      style = (p + p / 4) % 4;
      add_basis(pack_vec(pick_comp(style), pick_comp(style), pick_comp(style)),
                pack_vec(pick_comp(style), pick_comp(style), pick_comp(style)),
                pack_vec(pick_comp(style), pick_comp(style), pick_comp(style)));
      if (style == 1) begin
        add_write(REG_CORNER, REG_W'({$urandom, $urandom}));
        add_write(REG_NONE, REG_W'({$urandom, $urandom}));
      end
      for (int n = 0; n < PHASE_RAYS; n++) begin
        pick = $urandom_range(15);
        if (pick == 0) begin
          u = ($urandom_range(1) != 0) ? COORD_MAX : COORD_ONE;
          v = ($urandom_range(1) != 0) ? 17'd0 : COORD_ONE;
        end else if (pick < 3) begin
          u = COORD_W'($urandom_range(COORD_MAX));
          v = COORD_W'($urandom_range(COORD_MAX));
        end else begin
          u = COORD_W'($urandom_range(FRAC_SCALE));
          v = COORD_W'($urandom_range(FRAC_SCALE));
        end
        add_ray(u, v, gap);
        if (n == PHASE_RAYS / 2) add_drain();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pend_q.size() != 0 || start || acc_cnt != chk_cnt) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    if (ray_exp_q.size() != 0) begin
      $display("%0d expected results never arrived", ray_exp_q.size());
      mism_cnt += ray_exp_q.size();
    end

    $display("%0d rays checked across %0d camera bases, %0d of them degenerate",
             chk_cnt, basis_cnt, degen_cnt);
    $display("%0d mismatches, %0d cycles", mism_cnt, cycle_cnt);
    if (mism_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/crdg_pkg.sv
rtl/camera_ray_direction_generator.sv
tb/tb_camera_ray_direction_generator.sv
